/* hw/rtl/dtt_pkg.sv */
`default_nettype none

package dtt_pkg;

   // fixed field widths of the request and response beats
   localparam int OP_W     = 3;
   localparam int ID_W     = 4;
   localparam int PERIOD_W = 32;
   localparam int NOW_W    = 48;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 3'd0,
      OP_CANCEL  = 3'd1,
      OP_REFRESH = 3'd2,
      OP_RESET   = 3'd3,
      OP_QUERY   = 3'd4,
      OP_COLLECT = 3'd5
   } opcode_type;

   typedef enum logic {
      ALU_ADD = 1'b0,  // saturating add
      ALU_SUB = 1'b1   // subtract, floored at zero; flags valid
   } alu_op_type;

   typedef struct packed {
      logic lt;  // (a, ia) before (b, ib)
      logic le;  // a <= b
   } alu_flags_type;

endpackage

`default_nettype wire

/* hw/rtl/deadline_timer_table_core.sv */
`default_nettype none

// Deadline timer table: NUM_SLOTS timer slots with deadline, period and
// recurring mark in one single-port RAM; active marks live in flops.
// Request beat (req_valid/req_ready): opcode, slot, period, recurring,
// from-now flag and the current time. Response beats (rsp_valid/rsp_ready)
// carry ok, id, wake request, wait time, has-timer, expired and last.
// Collect returns one beat per due timer in (deadline, slot) order, or one
// beat if none is due; every other opcode returns one beat.
// req_ready is high only when the sequencer is idle. Every slot pass goes
// through the RAM one entry per cycle into one shared add/compare unit.
// Collect marks the due timers in one pass, then picks each beat in a
// further pass.
// A response register sits on the output: a finished beat waits there
// while the sequencer goes on, and with a stalled receiver the sequencer
// holds its next beat until the register frees up.
// Reset clears all active marks, the wake-pending flag and the response
// register; the RAM contents are not cleared and are only used for
// active slots.

module deadline_timer_table_core
   import dtt_pkg::*;
#(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 48
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [ID_W-1:0]     req_slot_id,
   input  wire logic [PERIOD_W-1:0] req_period_ms,
   input  wire logic                req_is_recurring,
   input  wire logic                req_from_now,
   input  wire logic [NOW_W-1:0]    req_now_ms,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_ok,
   output logic      [ID_W-1:0]     rsp_result_id,
   output logic                     rsp_wake_request,
   output logic      [NOW_W-1:0]    rsp_wait_ms,
   output logic                     rsp_has_timer,
   output logic                     rsp_expired_valid,
   output logic                     rsp_last
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int AW = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
   localparam int DW = TIME_BITS + PERIOD_W + 1;
   localparam logic [TIME_BITS-1:0] TMAX = '1;
   localparam logic [CW-1:0]        NSLOT = CW'(NUM_SLOTS);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECODE = 9'b000000010,
      S_FREE   = 9'b000000100,
      S_ADDW   = 9'b000001000,
      S_RDSLOT = 9'b000010000,
      S_SLOT   = 9'b000100000,
      S_RESET2 = 9'b001000000,
      S_SCAN   = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   // what a slot pass is looking for
   typedef enum logic [1:0] {
      M_FRONT = 2'd0,  // is the target slot first in order
      M_MIN   = 2'd1,  // earliest active slot
      M_DUE   = 2'd2,  // mark due slots, count them
      M_PICK  = 2'd3   // earliest due slot not yet sent
   } mode_type;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [ID_W-1:0]        sid_ff, sid_in;
   logic [PERIOD_W-1:0]    per_ff, per_in;
   logic                   rec_ff, rec_in;
   logic                   fnow_ff, fnow_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [TIME_BITS-1:0]   ref_d_ff, ref_d_in;
   logic [PERIOD_W-1:0]    best_per_ff, best_per_in;
   logic                   best_rec_ff, best_rec_in;
   logic                   have_ff, have_in;
   logic                   front_ff, front_in;
   logic                   surv_ff, surv_in;
   logic                   more_ff, more_in;
   logic [NUM_SLOTS-1:0]   active_ff, active_in;
   logic [NUM_SLOTS-1:0]   due_ff, due_in;
   logic [CW-1:0]          act_cnt_ff, act_cnt_in;
   logic [CW-1:0]          n_ff, n_in;
   logic                   wake_pend_ff, wake_pend_in;
   logic [CW-1:0]          scan_cnt_ff, scan_cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [SW-1:0]          rd_idx_ff, rd_idx_in;

   // pending response
   logic                   res_ok_ff, res_ok_in;
   logic [ID_W-1:0]        res_id_ff, res_id_in;
   logic                   res_wake_ff, res_wake_in;
   logic [TIME_BITS-1:0]   res_wait_ff, res_wait_in;
   logic                   res_ev_ff, res_ev_in;
   logic                   res_last_ff, res_last_in;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff;
   logic [ID_W-1:0]        rsp_id_ff;
   logic                   rsp_wake_ff;
   logic [TIME_BITS-1:0]   rsp_wait_ff;
   logic                   rsp_has_ff;
   logic                   rsp_ev_ff;
   logic                   rsp_last_ff;
   logic                   rsp_load;

   // slot RAM: {recurring, period, deadline}
   logic                   ram_en;
   logic                   ram_we;
   logic [SW-1:0]          ram_addr;
   logic [DW-1:0]          ram_wdata;
   logic [DW-1:0]          ram_rdata;
   logic [TIME_BITS-1:0]   q_dl;
   logic [PERIOD_W-1:0]    q_per;
   logic                   q_rec;

   // shared unit
   alu_op_type             alu_op;
   logic [AW-1:0]          alu_a;
   logic [AW-1:0]          alu_b;
   logic [AW-1:0]          alu_res;
   alu_flags_type          alu_flags;
   logic [TIME_BITS-1:0]   alu_t;

   logic                   sid_ok;
   logic                   act_i;
   logic                   scan_done;

   assign q_dl  = ram_rdata[TIME_BITS-1:0];
   assign q_per = ram_rdata[TIME_BITS +: PERIOD_W];
   assign q_rec = ram_rdata[DW-1];
   assign alu_t = alu_res[TIME_BITS-1:0];

   assign sid_ok    = 32'(sid_ff) < NUM_SLOTS;
   assign act_i     = active_ff[rd_idx_ff];
   assign scan_done = (scan_cnt_ff == NSLOT) && !rd_vld_ff;

   dtt_ram #(
      .WIDTH (DW),
      .DEPTH (NUM_SLOTS)
   ) u_slots (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   dtt_alu #(
      .W  (AW),
      .TB (TIME_BITS),
      .SW (SW)
   ) u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .ia    (rd_idx_ff),
      .ib    (slot_ff),
      .res   (alu_res),
      .flags (alu_flags)
   );

   // operand select for the shared unit
   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = AW'(q_dl);
      alu_b  = AW'(ref_d_ff);
      case (state_ff)
         S_ADDW: begin
            alu_op = ALU_ADD;
            alu_a  = AW'(now_ff);
            alu_b  = AW'(per_ff);
         end
         S_SLOT: begin
            if (op_ff == OP_REFRESH) begin
               alu_op = ALU_ADD;
               alu_a  = AW'(now_ff);
            end
            alu_b = AW'(q_per);
         end
         S_RESET2: begin
            alu_op = ALU_ADD;
            alu_a  = AW'(ref_d_ff);
            alu_b  = AW'(per_ff);
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (mode_ff == M_DUE) begin
                  alu_b = AW'(now_ff);
               end
            end else if (mode_ff == M_PICK) begin
               // reload of the picked slot
               alu_op = ALU_ADD;
               alu_a  = AW'(now_ff);
               alu_b  = AW'(best_per_ff);
            end else begin
               // wait time of the earliest slot
               alu_a = AW'(ref_d_ff);
               alu_b = AW'(now_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      op_in        = op_ff;
      sid_in       = sid_ff;
      per_in       = per_ff;
      rec_in       = rec_ff;
      fnow_in      = fnow_ff;
      now_in       = now_ff;
      slot_in      = slot_ff;
      ref_d_in     = ref_d_ff;
      best_per_in  = best_per_ff;
      best_rec_in  = best_rec_ff;
      have_in      = 1'b0;
      front_in     = 1'b1;
      surv_in      = surv_ff;
      more_in      = more_ff;
      active_in    = active_ff;
      due_in       = due_ff;
      act_cnt_in   = act_cnt_ff;
      n_in         = n_ff;
      wake_pend_in = wake_pend_ff;
      scan_cnt_in  = '0;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      res_ok_in    = res_ok_ff;
      res_id_in    = res_id_ff;
      res_wake_in  = res_wake_ff;
      res_wait_in  = res_wait_ff;
      res_ev_in    = res_ev_ff;
      res_last_in  = res_last_ff;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = slot_ff;
      ram_wdata    = '0;
      rsp_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               sid_in   = req_slot_id;
               per_in   = req_period_ms;
               rec_in   = req_is_recurring;
               fnow_in  = req_from_now;
               now_in   = TIME_BITS'(req_now_ms);
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_ok_in   = 1'b0;
            res_id_in   = '0;
            res_wake_in = 1'b0;
            res_wait_in = '0;
            res_ev_in   = 1'b0;
            res_last_in = 1'b1;
            more_in     = 1'b0;
            slot_in     = sid_ok ? SW'(sid_ff) : '0;
            state_in    = S_RESP;
            case (op_ff)
               OP_ADD: begin
                  if (act_cnt_ff != NSLOT) begin
                     state_in = S_FREE;
                  end
               end
               OP_CANCEL: begin
                  res_id_in = sid_ff;
                  if (sid_ok && active_ff[SW'(sid_ff)]) begin
                     active_in[SW'(sid_ff)] = 1'b0;
                     act_cnt_in = act_cnt_ff - CW'(1);
                     res_ok_in  = 1'b1;
                  end
               end
               OP_REFRESH, OP_RESET: begin
                  res_id_in = sid_ff;
                  if (sid_ok && active_ff[SW'(sid_ff)]) begin
                     state_in = S_RDSLOT;
                  end
               end
               OP_QUERY: begin
                  wake_pend_in = 1'b0;
                  mode_in      = M_MIN;
                  state_in     = S_SCAN;
               end
               OP_COLLECT: begin
                  n_in     = '0;
                  surv_in  = 1'b0;
                  mode_in  = M_DUE;
                  state_in = S_SCAN;
               end
               default: begin
               end
            endcase
         end

         // lowest free slot; the table is known not to be full
         S_FREE: begin
            if (!active_ff[scan_cnt_ff[SW-1:0]]) begin
               slot_in  = scan_cnt_ff[SW-1:0];
               state_in = S_ADDW;
            end else begin
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end
         end

         S_ADDW: begin
            ram_en             = 1'b1;
            ram_we             = 1'b1;
            ram_wdata          = {rec_ff, per_ff, alu_t};
            active_in[slot_ff] = 1'b1;
            act_cnt_in         = act_cnt_ff + CW'(1);
            ref_d_in           = alu_t;
            mode_in            = M_FRONT;
            state_in           = S_SCAN;
         end

         S_RDSLOT: begin
            ram_en   = 1'b1;
            state_in = S_SLOT;
         end

         S_SLOT: begin
            if (op_ff == OP_REFRESH) begin
               ram_en    = 1'b1;
               ram_we    = 1'b1;
               ram_wdata = {q_rec, q_per, alu_t};
               res_ok_in = 1'b1;
               state_in  = S_RESP;
            end else if (q_per == per_ff && !fnow_ff) begin
               // same period, old start: nothing moves
               res_ok_in = 1'b1;
               state_in  = S_RESP;
            end else begin
               rec_in   = q_rec;
               ref_d_in = fnow_ff ? now_ff : alu_t;
               state_in = S_RESET2;
            end
         end

         S_RESET2: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = {rec_ff, per_ff, alu_t};
            ref_d_in  = alu_t;
            mode_in   = M_FRONT;
            state_in  = S_SCAN;
         end

         S_SCAN: begin
            have_in     = have_ff;
            front_in    = front_ff;
            scan_cnt_in = scan_cnt_ff;

            // compare the entry read last cycle
            if (rd_vld_ff) begin
               case (mode_ff)
                  M_FRONT: begin
                     if (act_i && rd_idx_ff != slot_ff && alu_flags.lt) begin
                        front_in = 1'b0;
                     end
                  end
                  M_MIN: begin
                     if (act_i && (!have_ff || alu_flags.lt)) begin
                        have_in  = 1'b1;
                        ref_d_in = q_dl;
                        slot_in  = rd_idx_ff;
                     end
                  end
                  M_DUE: begin
                     if (act_i && alu_flags.le) begin
                        due_in[rd_idx_ff] = 1'b1;
                        n_in = n_ff + CW'(1);
                     end
                     if (act_i && !(alu_flags.le && !q_rec)) begin
                        surv_in = 1'b1;
                     end
                  end
                  M_PICK: begin
                     if (due_ff[rd_idx_ff] && (!have_ff || alu_flags.lt)) begin
                        have_in     = 1'b1;
                        ref_d_in    = q_dl;
                        slot_in     = rd_idx_ff;
                        best_per_in = q_per;
                        best_rec_in = q_rec;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // issue the next read
            if (scan_cnt_ff != NSLOT) begin
               ram_en      = 1'b1;
               ram_addr    = scan_cnt_ff[SW-1:0];
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_cnt_ff[SW-1:0];
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end

            if (scan_done) begin
               state_in = S_RESP;
               case (mode_ff)
                  M_FRONT: begin
                     res_ok_in = 1'b1;
                     res_id_in = ID_W'(slot_ff);
                     if (front_ff && !wake_pend_ff) begin
                        res_wake_in  = 1'b1;
                        wake_pend_in = 1'b1;
                     end
                  end
                  M_MIN: begin
                     res_ok_in   = 1'b1;
                     res_wait_in = have_ff ? alu_t : TMAX;
                  end
                  M_DUE: begin
                     res_ok_in = 1'b1;
                     if (n_ff != '0) begin
                        mode_in     = M_PICK;
                        state_in    = S_SCAN;
                        scan_cnt_in = '0;
                        have_in     = 1'b0;
                     end
                  end
                  M_PICK: begin
                     if (best_rec_ff) begin
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_addr  = slot_ff;
                        ram_wdata = {1'b1, best_per_ff, alu_t};
                     end else begin
                        active_in[slot_ff] = 1'b0;
                        act_cnt_in = act_cnt_ff - CW'(1);
                     end
                     due_in[slot_ff] = 1'b0;
                     n_in        = n_ff - CW'(1);
                     res_ok_in   = 1'b1;
                     res_id_in   = ID_W'(slot_ff);
                     res_ev_in   = 1'b1;
                     res_last_in = (n_ff == CW'(1));
                     more_in     = (n_ff != CW'(1));
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if (more_ff) begin
                  mode_in  = M_PICK;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_FRONT;
         active_ff    <= '0;
         due_ff       <= '0;
         act_cnt_ff   <= '0;
         n_ff         <= '0;
         wake_pend_ff <= 1'b0;
         scan_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         have_ff      <= 1'b0;
         front_ff     <= 1'b1;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         active_ff    <= active_in;
         due_ff       <= due_in;
         act_cnt_ff   <= act_cnt_in;
         n_ff         <= n_in;
         wake_pend_ff <= wake_pend_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         have_ff      <= have_in;
         front_ff     <= front_in;
         more_ff      <= more_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sid_ff      <= sid_in;
      per_ff      <= per_in;
      rec_ff      <= rec_in;
      fnow_ff     <= fnow_in;
      now_ff      <= now_in;
      slot_ff     <= slot_in;
      ref_d_ff    <= ref_d_in;
      best_per_ff <= best_per_in;
      best_rec_ff <= best_rec_in;
      surv_ff     <= surv_in;
      rd_idx_ff   <= rd_idx_in;
      res_ok_ff   <= res_ok_in;
      res_id_ff   <= res_id_in;
      res_wake_ff <= res_wake_in;
      res_wait_ff <= res_wait_in;
      res_ev_ff   <= res_ev_in;
      res_last_ff <= res_last_in;
      if (rsp_load) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_id_ff   <= res_id_ff;
         rsp_wake_ff <= res_wake_ff;
         rsp_wait_ff <= res_wait_ff;
         // collect reports the table as it stands after all reloads
         rsp_has_ff  <= (op_ff == OP_COLLECT) ? surv_ff : (act_cnt_ff != '0);
         rsp_ev_ff   <= res_ev_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_result_id     = rsp_id_ff;
   assign rsp_wake_request  = rsp_wake_ff;
   assign rsp_wait_ms       = NOW_W'(rsp_wait_ff);
   assign rsp_has_timer     = rsp_has_ff;
   assign rsp_expired_valid = rsp_ev_ff;
   assign rsp_last          = rsp_last_ff;

   a_act_count: assert property (@(posedge clock) disable iff (reset)
      $countones(active_ff) == int'(act_cnt_ff))
      else $error("active count out of step with active marks");

   a_due_count: assert property (@(posedge clock) disable iff (reset)
      $countones(due_ff) == int'(n_ff))
      else $error("due count out of step with due marks");

   a_due_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (due_ff == '0))
      else $error("collect left due slots unsent");

   a_pick_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && mode_ff == M_PICK) |-> (n_ff != '0))
      else $error("pick pass with no due slot left");

   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wake_request) |-> (rsp_ok && !rsp_expired_valid))
      else $error("wake request on a failed or expiry beat");

endmodule

`default_nettype wire

/* hw/rtl/dtt_ram.sv */
`default_nettype none

module dtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/dtt_alu.sv */
`default_nettype none

module dtt_alu
   import dtt_pkg::*;
#(
   parameter int W  = 48,
   parameter int TB = 48,
   parameter int SW = 4
) (
   input  wire alu_op_type     op,
   input  wire logic [W-1:0]   a,
   input  wire logic [W-1:0]   b,
   input  wire logic [SW-1:0]  ia,
   input  wire logic [SW-1:0]  ib,
   output logic      [W-1:0]   res,
   output alu_flags_type       flags
);

   localparam logic [W-1:0] TOP = W'({TB{1'b1}});

   logic [W:0]   sum;
   logic [W-1:0] b_op;
   logic         carry;
   logic         over;
   logic         eq;

   // one adder: a + b, or a + ~b + 1
   assign b_op  = (op == ALU_ADD) ? b : ~b;
   assign sum   = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, (op == ALU_SUB)};
   assign carry = sum[W];
   assign over  = (sum >> TB) != '0;
   assign eq    = (a == b);

   always_comb begin
      if (op == ALU_ADD) begin
         res = over ? TOP : sum[W-1:0];
      end else begin
         res = carry ? sum[W-1:0] : '0;
      end
   end

   assign flags.lt = !carry || (eq && (ia < ib));
   assign flags.le = !carry || eq;

endmodule

`default_nettype wire
